@@ rtl/core/mpe_pkg.sv @@
// mpe_pkg: shared types and constants for the matrix permute engine
// operation codes, controller states, command and status bundles
// no dependencies
`timescale 1ns / 1ps

package mpe_pkg;

  // operation codes carried in func
  typedef enum logic [3:0] {
    FN_SIZE        = 4'd0,
    FN_WRITE       = 4'd1,
    FN_READ        = 4'd2,
    FN_SWAPCELL    = 4'd3,
    FN_SWAPROWS    = 4'd4,
    FN_SWAPCOLS    = 4'd5,
    FN_REVROW      = 4'd6,
    FN_REVCOL      = 4'd7,
    FN_MIRRORROWS  = 4'd8,
    FN_MIRRORCOLS  = 4'd9,
    FN_REVDIAG     = 4'd10,
    FN_SWAPDIAG    = 4'd11,
    FN_TRANSPOSE   = 4'd12,
    FN_ROTATE      = 4'd13,
    FN_SWAPNEIGH   = 4'd14
  } func_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DISPATCH,
    ST_SW_RD,
    ST_SW_WA,
    ST_SW_WB,
    ST_R1_RD,
    ST_R1_WR,
    ST_R2_INIT,
    ST_R2_CHK,
    ST_R2_RD,
    ST_R2_WR,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input transfer
    logic init;       // check operands, load loop limits
    logic init2;      // load limits for second rotate pass
    logic step;       // advance loop counters
    logic rd;         // read store at both pair addresses
    logic wr_swap_a;  // write first cell of pair
    logic wr_swap_b;  // write second cell of pair
    logic wr_cell;    // single cell write
    logic sc_wr;      // write scratch in rotate pass one
    logic sc_rd;      // read scratch in rotate pass two
    logic wr_rot;     // write store in rotate pass two
    logic finish;     // load result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [3:0] func;
    logic       ok;
    logic       empty;
    logic       last;
    logic       out_free;
  } sts_t;

  localparam int NEIGHBOURS = 8;
  localparam int NB_GAP     = 2;

  // neighbour row offset plus one, row-major order of offsets
  function automatic logic [1:0] nb_row(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // neighbour column offset plus one
  function automatic logic [1:0] nb_col(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0, 3'd3, 3'd5: c = 2'd0;
      3'd1, 3'd6:       c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/matrix_permute_engine.sv @@
// Matrix permute engine: one item at a time. Size, write, read and rejected items go
// straight from dispatch to the result. Each cell exchange is a read of the pair and two
// writes on the store's single write port; rotate copies the store through a scratch store.
// The next item is taken once the result is loaded into the output register.
// Synchronous reset clears the counts to zero; cell contents are undefined until written.
`timescale 1ns / 1ps

module matrix_permute_engine #(
  parameter int MAX_DIM    = 16,
  parameter int CELL_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         func,
  input  logic [4:0]         row_a,
  input  logic [4:0]         col_a,
  input  logic [3:0]         row_b,
  input  logic [3:0]         col_b,
  input  logic signed [4:0]  diag_offset,
  input  logic signed [31:0] data_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic               ok
);
  import mpe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and address datapath
  mpe_datapath #(
    .MAX_DIM    (MAX_DIM),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .row_a       (row_a),
    .col_a       (col_a),
    .row_b       (row_b),
    .col_b       (col_b),
    .diag_offset (diag_offset),
    .data_value  (data_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .ok          (ok)
  );

endmodule

@@ rtl/core/mpe_ctrl.sv @@
// mpe_ctrl: sequencing state machine of the matrix permute engine
// issues reads, writes and counter steps to mpe_datapath
// depends on mpe_pkg
`timescale 1ns / 1ps

module mpe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpe_pkg::sts_t sts,
  output mpe_pkg::cmd_t cmd
);
  import mpe_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.init = 1'b1;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!sts.ok) begin
          state_next = ST_DONE;
        end else begin
          case (sts.func)
            FN_SIZE: state_next = ST_DONE;
            FN_WRITE: begin
              cmd.wr_cell = 1'b1;
              state_next = ST_DONE;
            end
            FN_READ: begin
              cmd.rd = 1'b1;
              state_next = ST_DONE;
            end
            FN_ROTATE: state_next = sts.empty ? ST_R2_INIT : ST_R1_RD;
            default: state_next = sts.empty ? ST_DONE : ST_SW_RD;
          endcase
        end
      end
      // one exchange: read pair, write both halves
      ST_SW_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_SW_WA;
      end
      ST_SW_WA: begin
        cmd.wr_swap_a = 1'b1;
        state_next = ST_SW_WB;
      end
      ST_SW_WB: begin
        cmd.wr_swap_b = 1'b1;
        cmd.step = 1'b1;
        state_next = sts.last ? ST_DONE : ST_SW_RD;
      end
      // rotate pass one: store to scratch
      ST_R1_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_R1_WR;
      end
      ST_R1_WR: begin
        cmd.sc_wr = 1'b1;
        cmd.step = 1'b1;
        state_next = sts.last ? ST_R2_INIT : ST_R1_RD;
      end
      // rotate pass two: scratch back to store
      ST_R2_INIT: begin
        cmd.init2 = 1'b1;
        state_next = ST_R2_CHK;
      end
      ST_R2_CHK: begin
        state_next = sts.empty ? ST_DONE : ST_R2_RD;
      end
      ST_R2_RD: begin
        cmd.sc_rd = 1'b1;
        state_next = ST_R2_WR;
      end
      ST_R2_WR: begin
        cmd.wr_rot = 1'b1;
        cmd.step = 1'b1;
        state_next = sts.last ? ST_DONE : ST_R2_RD;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // checks
  a_wr_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_swap_a, cmd.wr_swap_b, cmd.wr_cell, cmd.wr_rot}))
    else $error("more than one store write at once");

  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_SW_WA |=> state == ST_SW_WB)
    else $error("exchange left half done");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over a waiting result");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_EVAL)
    else $error("accepted transfer not evaluated");

endmodule

@@ rtl/core/mpe_datapath.sv @@
// mpe_datapath: cell store, scratch store, loop counters, address generation
// and result register of the matrix permute engine
// depends on mpe_pkg
`timescale 1ns / 1ps

module mpe_datapath #(
  parameter int MAX_DIM    = 16,
  parameter int CELL_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  mpe_pkg::cmd_t      cmd,
  output mpe_pkg::sts_t      sts,
  input  logic [3:0]         func,
  input  logic [4:0]         row_a,
  input  logic [4:0]         col_a,
  input  logic [3:0]         row_b,
  input  logic [3:0]         col_b,
  input  logic signed [4:0]  diag_offset,
  input  logic signed [31:0] data_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic               ok
);
  import mpe_pkg::*;

  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int IW    = ((CW > 5) ? CW : 5) + 1;
  localparam int XW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [3:0]            f_func;
  logic [4:0]            f_ra, f_ca;
  logic [3:0]            f_rb, f_cb;
  logic [4:0]            f_d;
  logic [31:0]           f_data;
  logic [CW-1:0]         rows, cols;
  logic [IW-1:0]         cnt_o, cnt_i, olim, ilim, len_r;
  logic                  ok_r;
  logic [CELL_WIDTH-1:0] qa, qb, sq;
  logic [CELL_WIDTH-1:0] store   [DEPTH];
  logic [CELL_WIDTH-1:0] scratch [DEPTH];

  logic [IW-1:0] ra, ca, rb, cb, rr, cc, maxd, one, dpos, n_dim, ilim_eff;
  logic [4:0]    dmag;
  logic [IW-1:0] r0, c0;
  logic signed [IW:0] lenr, lenc, len_s;
  logic          diag_ok, neigh_ok;
  logic [IW-1:0] dr, dc;
  logic          ok_e;
  logic [IW-1:0] olim_e, ilim_e, ost_e;
  logic [IW-1:0] ar, ac, br, bc, nbr, nbc;
  logic [AW-1:0] addr_a, addr_b, addr_src, addr_dst, raddr_a, waddr;
  logic          we;
  logic [CELL_WIDTH-1:0] wdata;
  logic          out_free;
  logic signed [31:0] rv;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r[XW-1:0]) * AW'(MAX_DIM) + AW'(c[XW-1:0]);
  endfunction

  // capture input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_func <= func;
      f_ra   <= row_a;
      f_ca   <= col_a;
      f_rb   <= row_b;
      f_cb   <= col_b;
      f_d    <= diag_offset;
      f_data <= data_value;
    end
  end

  assign ra    = IW'(f_ra);
  assign ca    = IW'(f_ca);
  assign rb    = IW'(f_rb);
  assign cb    = IW'(f_cb);
  assign rr    = IW'(rows);
  assign cc    = IW'(cols);
  assign maxd  = IW'(MAX_DIM);
  assign one   = IW'(1);
  assign dpos  = IW'(f_d[3:0]);
  assign n_dim = (rr > cc) ? rr : cc;

  // diagonal start and length
  always_comb begin
    dmag  = f_d[4] ? (~f_d + 5'd1) : f_d;
    r0    = f_d[4] ? IW'(dmag) : '0;
    c0    = f_d[4] ? '0 : IW'(dmag);
    lenr  = $signed({1'b0, rr}) - $signed({1'b0, r0});
    lenc  = $signed({1'b0, cc}) - $signed({1'b0, c0});
    len_s = (lenc < lenr) ? lenc : lenr;
    diag_ok = len_s > $signed((IW + 1)'(1));
  end

  // neighbourhood exchange checks
  always_comb begin
    dr = (ra > rb) ? ra - rb : rb - ra;
    dc = (ca > cb) ? ca - cb : cb - ca;
    neigh_ok = !(dr < IW'(NB_GAP) && dc < IW'(NB_GAP))
             && ra >= one && ca >= one && ra + IW'(NB_GAP) <= rr && ca + IW'(NB_GAP) <= cc
             && rb >= one && cb >= one && rb + IW'(NB_GAP) <= rr && cb + IW'(NB_GAP) <= cc;
  end

  // operand checks and loop limits
  always_comb begin
    ok_e   = 1'b0;
    olim_e = one;
    ilim_e = one;
    ost_e  = '0;
    case (f_func)
      FN_SIZE:  ok_e = (ra <= maxd) && (ca <= maxd);
      FN_WRITE, FN_READ: ok_e = (ra < rr) && (ca < cc);
      FN_SWAPCELL: ok_e = (ra < rr) && (ca < cc) && (rb < rr) && (cb < cc);
      FN_SWAPROWS: begin
        ok_e = (ra < rr) && (rb < rr);
        ilim_e = cc;
      end
      FN_SWAPCOLS: begin
        ok_e = (ca < cc) && (cb < cc);
        ilim_e = rr;
      end
      FN_REVROW: begin
        ok_e = (ra < rr);
        ilim_e = cc >> 1;
      end
      FN_REVCOL: begin
        ok_e = (ca < cc);
        ilim_e = rr >> 1;
      end
      FN_MIRRORROWS: begin
        ok_e = 1'b1;
        olim_e = rr;
        ilim_e = cc >> 1;
      end
      FN_MIRRORCOLS: begin
        ok_e = 1'b1;
        olim_e = cc;
        ilim_e = rr >> 1;
      end
      FN_REVDIAG: begin
        ok_e = diag_ok;
        ilim_e = len_s[IW-1:0] >> 1;
      end
      FN_SWAPDIAG: begin
        ok_e = (rr == cc) && !f_d[4] && (dpos < rr);
        ilim_e = rr - dpos;
      end
      FN_TRANSPOSE: begin
        ok_e = (rr == cc);
        olim_e = rr;
        ost_e = one;
      end
      FN_ROTATE: begin
        ok_e = 1'b1;
        olim_e = cc;
        ilim_e = rr;
      end
      FN_SWAPNEIGH: begin
        ok_e = neigh_ok;
        ilim_e = IW'(NEIGHBOURS);
      end
      default: ok_e = 1'b0;
    endcase
  end

  // transpose inner loop shrinks with the diagonal index
  assign ilim_eff = (f_func == FN_TRANSPOSE) ? rr - cnt_o : ilim;

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cnt_o <= ost_e;
      cnt_i <= '0;
      olim  <= olim_e;
      ilim  <= ilim_e;
      ok_r  <= ok_e;
      len_r <= len_s[IW-1:0];
    end else if (cmd.init2) begin
      cnt_o <= '0;
      cnt_i <= '0;
      olim  <= n_dim;
      ilim  <= n_dim;
    end else if (cmd.step) begin
      if (cnt_i == ilim_eff - one) begin
        cnt_i <= '0;
        cnt_o <= cnt_o + one;
      end else begin
        cnt_i <= cnt_i + one;
      end
    end
  end

  // pair address generation
  always_comb begin
    nbr = IW'(nb_row(cnt_i[2:0]));
    nbc = IW'(nb_col(cnt_i[2:0]));
    ar = ra;
    ac = ca;
    br = rb;
    bc = cb;
    case (f_func)
      FN_SWAPROWS: begin
        ac = cnt_i;
        bc = cnt_i;
      end
      FN_SWAPCOLS: begin
        ar = cnt_i;
        br = cnt_i;
      end
      FN_REVROW: begin
        ac = cnt_i;
        br = ra;
        bc = cc - one - cnt_i;
      end
      FN_REVCOL: begin
        ar = cnt_i;
        br = rr - one - cnt_i;
        bc = ca;
      end
      FN_MIRRORROWS: begin
        ar = cnt_o;
        ac = cnt_i;
        br = cnt_o;
        bc = cc - one - cnt_i;
      end
      FN_MIRRORCOLS: begin
        ar = cnt_i;
        ac = cnt_o;
        br = rr - one - cnt_i;
        bc = cnt_o;
      end
      FN_REVDIAG: begin
        ar = r0 + cnt_i;
        ac = c0 + cnt_i;
        br = r0 + len_r - one - cnt_i;
        bc = c0 + len_r - one - cnt_i;
      end
      FN_SWAPDIAG: begin
        ar = cnt_i;
        ac = dpos + cnt_i;
        br = dpos + cnt_i;
        bc = cnt_i;
      end
      FN_TRANSPOSE: begin
        ar = cnt_i;
        ac = cnt_o + cnt_i;
        br = cnt_o + cnt_i;
        bc = cnt_i;
      end
      FN_SWAPNEIGH: begin
        ar = ra + nbr - one;
        ac = ca + nbc - one;
        br = rb + nbr - one;
        bc = cb + nbc - one;
      end
      default: ;
    endcase
  end

  assign addr_a   = cell_addr(ar, ac);
  assign addr_b   = cell_addr(br, bc);
  assign addr_src = cell_addr(rr - one - cnt_i, cnt_o);
  assign addr_dst = cell_addr(cnt_o, cnt_i);
  assign raddr_a  = (f_func == FN_ROTATE) ? addr_src : addr_a;

  // store write port
  always_comb begin
    we = cmd.wr_swap_a | cmd.wr_swap_b | cmd.wr_cell | cmd.wr_rot;
    waddr = addr_a;
    wdata = qb;
    if (cmd.wr_swap_b) begin
      waddr = addr_b;
      wdata = qa;
    end else if (cmd.wr_cell) begin
      wdata = CELL_WIDTH'({32'd0, f_data});
    end else if (cmd.wr_rot) begin
      waddr = addr_dst;
      wdata = (cnt_o < cc && cnt_i < rr) ? sq : '0;
    end
  end

  // cell store, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (cmd.rd) begin
      qa <= store[raddr_a];
      qb <= store[addr_b];
    end
  end

  // scratch store for rotation
  always_ff @(posedge clk) begin
    if (cmd.sc_wr) begin
      scratch[addr_dst] <= qa;
    end
    if (cmd.sc_rd) begin
      sq <= scratch[addr_dst];
    end
  end

  // counts and result register
  assign out_free = !out_valid || !out_stall;
  assign rv = 32'(64'(signed'(qa)));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= '0;
      cols      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (f_func == FN_SIZE && ok_r) begin
          rows <= CW'(f_ra);
          cols <= CW'(f_ca);
        end else if (f_func == FN_ROTATE) begin
          rows <= cols;
          cols <= rows;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value <= (f_func == FN_READ && ok_r) ? rv : '0;
      ok         <= ok_r;
    end
  end

  assign sts.func     = f_func;
  assign sts.ok       = ok_r;
  assign sts.empty    = (cnt_o >= olim) || (ilim_eff == '0);
  assign sts.last     = (cnt_o == olim - one) && (cnt_i == ilim_eff - one);
  assign sts.out_free = out_free;

endmodule
